// ----- sv/svd_pkg.sv -----
// shared types and constants for the servo envelope slew driver
package svd_pkg;

  // tick modes carried in tuser
  localparam logic [1:0] MODE_AUDIO  = 2'd0;
  localparam logic [1:0] MODE_CLOSE  = 2'd1;
  localparam logic [1:0] MODE_ATTACH = 2'd2;

  // register indexes on the configuration channel
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_RELEASE = 3'd1;
  localparam logic [2:0] REG_THRESH  = 3'd2;
  localparam logic [2:0] REG_STEP_UP = 3'd3;
  localparam logic [2:0] REG_STEP_DN = 3'd4;
  localparam logic [2:0] REG_DEADBND = 3'd5;
  localparam logic [2:0] REG_OPEN    = 3'd6;
  localparam logic [2:0] REG_CLOSED  = 3'd7;

  // register reset values
  localparam logic [12:0] RST_ATTACK  = 13'd1843;
  localparam logic [12:0] RST_RELEASE = 13'd901;
  localparam logic [15:0] RST_THRESH  = 16'd240;
  localparam logic [7:0]  RST_STEP_UP = 8'd20;
  localparam logic [7:0]  RST_STEP_DN = 8'd28;
  localparam logic [7:0]  RST_DEADBND = 8'd5;
  localparam logic [11:0] RST_OPEN    = 12'd1505;
  localparam logic [11:0] RST_CLOSED  = 12'd1774;

  // q12 constants
  localparam logic [12:0] Q12_ONE    = 13'd4096;
  localparam logic [12:0] SNAP_LIMIT = 13'd41;
  localparam logic [25:0] Q12_ROUND  = 26'd2048;

  // shared multiplier and duty division widths
  localparam int MUL_A_W     = 30;
  localparam int MUL_B_W     = 21;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int NUM_W       = 29;
  localparam int QEST_W      = 20;
  localparam int RECIP_SHIFT = 30;
  localparam int DUTY_W      = 14;

  // operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MUL_FILT,
    MUL_SPAN,
    MUL_NUM,
    MUL_QEST,
    MUL_CHK
  } mul_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_filt;
    logic     upd_slew;
    logic     ld_num;
    logic     ld_qest;
    logic     out_load;
  } svd_cmd_t;

endpackage

// ----- sv/svd_ctrl.sv -----
// controller state machine sequencing one tick through the datapath
module svd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output svd_pkg::svd_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILT = 4'd1;
  localparam logic [3:0] S_FUPD = 4'd2;
  localparam logic [3:0] S_SPAN = 4'd3;
  localparam logic [3:0] S_SLEW = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_QEST = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = svd_pkg::MUL_FILT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_FILT;
        end
      end
      S_FILT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = svd_pkg::MUL_FILT;
        state_d       = S_FUPD;
      end
      S_FUPD: begin
        cmd_o.upd_filt = 1'b1;
        state_d        = S_SPAN;
      end
      S_SPAN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = svd_pkg::MUL_SPAN;
        state_d       = S_SLEW;
      end
      S_SLEW: begin
        cmd_o.upd_slew = 1'b1;
        state_d        = S_NUM;
      end
      S_NUM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = svd_pkg::MUL_NUM;
        state_d       = S_QEST;
      end
      S_QEST: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = svd_pkg::MUL_QEST;
        cmd_o.ld_num  = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = svd_pkg::MUL_CHK;
        cmd_o.ld_qest = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a finished word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free)
    else $error("output word overwritten");

  // an accepted word starts the filter multiply next
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_FILT))
    else $error("accepted word did not start processing");

  // a loaded result is presented on the next cycle
  a_out_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not presented after load");
`endif

endmodule

// ----- sv/svd_dp.sv -----
// datapath: registers, filter, slew limiter and duty conversion on one multiplier
module svd_dp #(
  parameter int DUTY_BITS = 14,
  parameter int PERIOD_US = 20000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svd_pkg::svd_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [1:0]        mode_i,
  input  logic [12:0]       drive_level_i,
  input  logic [15:0]       envelope_i,
  input  logic              valid_req_i,
  input  logic              active_i,
  output logic [11:0]       pulse_us_o,
  output logic [13:0]       duty_o,
  output logic              moved_o,
  output logic              at_closed_o,
  output logic [12:0]       smoothed_level_o
);

  localparam logic [15:0] FULL_C   = 16'((64'd1 << DUTY_BITS) - 64'd1);
  localparam logic [15:0] PERIOD_C = 16'(PERIOD_US);
  localparam logic [15:0] HALF_C   = 16'(PERIOD_US / 2);
  localparam logic [svd_pkg::MUL_B_W-1:0] RECIP_C =
    svd_pkg::MUL_B_W'((64'd1 << svd_pkg::RECIP_SHIFT) / PERIOD_US);

  // configuration registers
  logic [12:0] atk_q, rel_q;
  logic [15:0] thr_q;
  logic [7:0]  sup_q, sdn_q, dbd_q;
  logic [11:0] open_q, closed_q;

  // tick state
  logic [11:0] pulse_q;
  logic [12:0] f_q;
  logic        moved_q;

  // latched input word
  logic [1:0]  mode_q;
  logic [12:0] drv_q;
  logic [15:0] env_q;
  logic        vreq_q, act_q;

  // multiplier and division registers
  logic [svd_pkg::PROD_W-1:0] prod_q;
  logic [svd_pkg::NUM_W-1:0]  num_q;
  logic [svd_pkg::QEST_W-1:0] qest_q;

  // output word registers
  logic [11:0] o_pulse_q;
  logic [13:0] o_duty_q;
  logic        o_moved_q, o_closed_q;
  logic [12:0] o_smooth_q;

  logic [svd_pkg::MUL_A_W-1:0] mul_a;
  logic [svd_pkg::MUL_B_W-1:0] mul_b;

  logic [12:0] drv_sat, raw, gain, gain_sat, diff, mag, f_new, f_clip;
  logic [13:0] fsum;
  logic [25:0] rnd_f;
  logic        raw_ge;

  logic [11:0] lo, range_w, span, tgt, tgt_c, err, pc_clamp, pulse_new;
  logic [12:0] nx;
  logic        hold, moved_new, do_slew;

  logic [svd_pkg::NUM_W-1:0]  n_w;
  logic [svd_pkg::MUL_A_W-1:0] rem;
  logic [svd_pkg::QEST_W-1:0] duty_full;

  // gated raw level and filter step
  always_comb begin
    drv_sat = (drv_q > svd_pkg::Q12_ONE) ? svd_pkg::Q12_ONE : drv_q;
    raw     = (!vreq_q || env_q < thr_q) ? 13'd0 : drv_sat;
    gain    = (raw > f_q) ? atk_q : rel_q;
    gain_sat = (gain > svd_pkg::Q12_ONE) ? svd_pkg::Q12_ONE : gain;
    raw_ge  = (raw >= f_q);
    diff    = raw_ge ? (raw - f_q) : (f_q - raw);
    rnd_f   = prod_q[25:0] + svd_pkg::Q12_ROUND;
    mag     = rnd_f[24:12];
    fsum    = {1'b0, f_q} + {1'b0, mag};
    if (raw_ge) begin
      f_clip = (fsum > {1'b0, svd_pkg::Q12_ONE}) ? svd_pkg::Q12_ONE : fsum[12:0];
    end else begin
      f_clip = (mag > f_q) ? 13'd0 : (f_q - mag);
    end
    f_new = (raw == 13'd0 && f_clip < svd_pkg::SNAP_LIMIT) ? 13'd0 : f_clip;
  end

  // target pulse and slew step
  always_comb begin
    lo      = (open_q < closed_q) ? open_q : closed_q;
    range_w = closed_q - lo;
    span    = rnd_f[23:12];
    tgt     = (mode_q == svd_pkg::MODE_AUDIO) ? (closed_q - span) : closed_q;
    if (tgt < lo) begin
      tgt_c = lo;
    end else if (tgt > closed_q) begin
      tgt_c = closed_q;
    end else begin
      tgt_c = tgt;
    end
    err  = (tgt_c > pulse_q) ? (tgt_c - pulse_q) : (pulse_q - tgt_c);
    hold = (tgt_c != closed_q) && (err < {4'd0, dbd_q});
    nx   = {1'b0, pulse_q};
    if (pulse_q < tgt_c) begin
      nx = {1'b0, pulse_q} + {5'd0, sup_q};
      if (nx > {1'b0, tgt_c}) begin
        nx = {1'b0, tgt_c};
      end
    end else if (pulse_q > tgt_c) begin
      nx = (pulse_q > {4'd0, sdn_q}) ? {1'b0, pulse_q - {4'd0, sdn_q}} : {1'b0, lo};
      if (nx < {1'b0, tgt_c}) begin
        nx = {1'b0, tgt_c};
      end
    end
    moved_new = !hold && (nx != {1'b0, pulse_q});
    if (nx[11:0] < lo) begin
      pulse_new = lo;
    end else if (nx[11:0] > closed_q) begin
      pulse_new = closed_q;
    end else begin
      pulse_new = nx[11:0];
    end
    do_slew = act_q && ((mode_q == svd_pkg::MODE_AUDIO) ||
              (mode_q == svd_pkg::MODE_CLOSE && pulse_q != closed_q));
    if (pulse_q < lo) begin
      pc_clamp = lo;
    end else if (pulse_q > closed_q) begin
      pc_clamp = closed_q;
    end else begin
      pc_clamp = pulse_q;
    end
  end

  // duty division by the period: reciprocal estimate and one correction
  always_comb begin
    n_w       = prod_q[svd_pkg::NUM_W-1:0] + {13'd0, HALF_C};
    rem       = {1'b0, num_q} - prod_q[svd_pkg::MUL_A_W-1:0];
    duty_full = qest_q + ((rem >= {14'd0, PERIOD_C}) ? 20'd1 : 20'd0);
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      svd_pkg::MUL_FILT: begin
        mul_a = {17'd0, diff};
        mul_b = {8'd0, gain_sat};
      end
      svd_pkg::MUL_SPAN: begin
        mul_a = {17'd0, f_q};
        mul_b = {9'd0, range_w};
      end
      svd_pkg::MUL_NUM: begin
        mul_a = {18'd0, pc_clamp};
        mul_b = {5'd0, FULL_C};
      end
      svd_pkg::MUL_QEST: begin
        mul_a = {1'b0, n_w};
        mul_b = RECIP_C;
      end
      svd_pkg::MUL_CHK: begin
        // estimate taken straight from the product, qest_q loads in this step
        mul_a = {10'd0, prod_q[svd_pkg::RECIP_SHIFT +: svd_pkg::QEST_W]};
        mul_b = {5'd0, PERIOD_C};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_q    <= svd_pkg::RST_ATTACK;
      rel_q    <= svd_pkg::RST_RELEASE;
      thr_q    <= svd_pkg::RST_THRESH;
      sup_q    <= svd_pkg::RST_STEP_UP;
      sdn_q    <= svd_pkg::RST_STEP_DN;
      dbd_q    <= svd_pkg::RST_DEADBND;
      open_q   <= svd_pkg::RST_OPEN;
      closed_q <= svd_pkg::RST_CLOSED;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        svd_pkg::REG_ATTACK:  atk_q    <= cfg_data_i[12:0];
        svd_pkg::REG_RELEASE: rel_q    <= cfg_data_i[12:0];
        svd_pkg::REG_THRESH:  thr_q    <= cfg_data_i;
        svd_pkg::REG_STEP_UP: sup_q    <= cfg_data_i[7:0];
        svd_pkg::REG_STEP_DN: sdn_q    <= cfg_data_i[7:0];
        svd_pkg::REG_DEADBND: dbd_q    <= cfg_data_i[7:0];
        svd_pkg::REG_OPEN:    open_q   <= cfg_data_i[11:0];
        svd_pkg::REG_CLOSED:  closed_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // filter level, kept pulse and moved flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q     <= '0;
      pulse_q <= svd_pkg::RST_CLOSED;
      moved_q <= 1'b0;
    end else begin
      if (cmd_i.upd_filt) begin
        case (mode_q)
          svd_pkg::MODE_AUDIO: begin
            if (act_q) begin
              f_q <= vreq_q ? f_new : 13'd0;
            end
          end
          svd_pkg::MODE_CLOSE:  f_q <= '0;
          svd_pkg::MODE_ATTACH: f_q <= '0;
          default: ;
        endcase
      end
      if (cmd_i.upd_slew) begin
        if (mode_q == svd_pkg::MODE_ATTACH) begin
          pulse_q <= closed_q;
          moved_q <= 1'b1;
        end else if (do_slew) begin
          moved_q <= moved_new;
          if (moved_new) begin
            pulse_q <= pulse_new;
          end
        end else begin
          moved_q <= 1'b0;
        end
      end
    end
  end

  // input latch, multiplier, division and output word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      drv_q  <= drive_level_i;
      env_q  <= envelope_i;
      vreq_q <= valid_req_i;
      act_q  <= active_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.ld_num) begin
      num_q <= n_w;
    end
    if (cmd_i.ld_qest) begin
      qest_q <= prod_q[svd_pkg::PROD_W-2:svd_pkg::RECIP_SHIFT];
    end
    if (cmd_i.out_load) begin
      o_pulse_q  <= pulse_q;
      o_duty_q   <= duty_full[svd_pkg::DUTY_W-1:0];
      o_moved_q  <= moved_q;
      o_closed_q <= (pulse_q == closed_q);
      o_smooth_q <= f_q;
    end
  end

  assign pulse_us_o       = o_pulse_q;
  assign duty_o           = o_duty_q;
  assign moved_o          = o_moved_q;
  assign at_closed_o      = o_closed_q;
  assign smoothed_level_o = o_smooth_q;

`ifndef NO_ASSERTIONS
  // filtered level stays within q12 unity
  a_filt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_q <= svd_pkg::Q12_ONE)
    else $error("filtered level above unity");

  // product register only changes on a multiply step
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.mul_en |=> $stable(prod_q))
    else $error("product changed outside a multiply step");

  // filter and slew updates never coincide
  a_upd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.upd_filt && cmd_i.upd_slew))
    else $error("filter and slew update in the same cycle");
`endif

endmodule

// ----- sv/servo_envelope_slew_driver_top.sv -----
// top level of the servo envelope slew driver
//
// one input word is one control tick; it yields exactly one output word
// input channel s_axis: tuser carries the tick mode (audio, close, attach),
// tdata carries drive level, envelope, valid_req and active
// output channel m_axis: tdata carries pulse width, duty count, moved flag,
// at_closed flag and the smoothed level after the tick
// configuration channel cfg: index selects one of eight registers; the user
// must write them only while no tick is in flight, the block does not
// enforce it; cfg_ready_o is always high; a tick runs the accept step, five
// passes through the single shared multiplier (filter, span, duty product,
// reciprocal, check) with the filter and slew update steps, and the output
// step, after which m_axis_tvalid is registered; no new word is taken until
// the tick is through; s_axis_tready is high only while the controller is
// idle; a finished word waits in the output register while the next tick is
// already taken; if the receiver stalls longer, the controller holds the
// next result in its last step until the register frees up
// reset: registers return to defaults, pulse to the closed value 1774 and
// the filtered level to zero; no output word is pending
module servo_envelope_slew_driver_top #(
  parameter int DUTY_BITS = 14,
  parameter int PERIOD_US = 20000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // drive_level[12:0], envelope[28:13], valid_req[29], active[30], zero[31]
  input  logic [31:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pulse_us[11:0], duty[25:12], moved[26], at_closed[27],
  // smoothed_level[40:28], zero[47:41]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  svd_pkg::svd_cmd_t cmd;
  logic [11:0] pulse_us;
  logic [13:0] duty;
  logic        moved, at_closed;
  logic [12:0] smoothed_level;

  assign cfg_ready_o = 1'b1;

  // tick sequencer
  svd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  svd_dp #(
    .DUTY_BITS (DUTY_BITS),
    .PERIOD_US (PERIOD_US)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mode_i           (s_axis_tuser),
    .drive_level_i    (s_axis_tdata[12:0]),
    .envelope_i       (s_axis_tdata[28:13]),
    .valid_req_i      (s_axis_tdata[29]),
    .active_i         (s_axis_tdata[30]),
    .pulse_us_o       (pulse_us),
    .duty_o           (duty),
    .moved_o          (moved),
    .at_closed_o      (at_closed),
    .smoothed_level_o (smoothed_level)
  );

  // output word packing
  assign m_axis_tdata = {7'd0, smoothed_level, at_closed, moved, duty, pulse_us};

endmodule
